// ===== design/assert_macros.svh =====
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/pprp_pkg.sv =====
`timescale 1ns / 1ps
package pprp_pkg;

  localparam int STEP_W      = 5;
  localparam int U_W         = 63;
  localparam int MAG_W       = 63;
  localparam int TERM_W      = 61;
  localparam int PROD_W      = 64;
  localparam int PART_W      = 48;
  localparam int PWM_W       = 12;
  localparam int CMD_W       = 13;
  localparam int POS_W       = 32;
  localparam int TW_OUT_W    = 32;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [STEP_W-1:0] STEP_IDLE = '0;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd25;

  localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, 60'd0};
  localparam logic [PWM_W-1:0]  PWM_MAX    = '1;

  localparam logic [23:0] RST_TARGET_STEP = 24'd229376;
  localparam logic [31:0] RST_GAIN_P      = 32'd1966080;
  localparam logic [31:0] RST_GAIN_D      = 32'd196608000;
  localparam logic [31:0] RST_GAIN_I      = 32'd3277;
  localparam logic [11:0] RST_PWM_FLOOR   = 12'd1290;
  localparam logic [11:0] RST_PWM_CEILING = 12'd2047;
  localparam logic [15:0] RST_PWM_SLOPE   = 16'd24236;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_STEP  = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_PWM_FLOOR    = 3'd4,
    REG_PWM_CEILING  = 3'd5,
    REG_PWM_SLOPE    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [23:0] target_step;
    logic [31:0] gain_p;
    logic [31:0] gain_d;
    logic [31:0] gain_i;
    logic [11:0] pwm_floor;
    logic [11:0] pwm_ceiling;
    logic [15:0] pwm_slope;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_TARGET,
    OP_ERROR,
    OP_DIFF,
    OP_LOAD_MAG,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_TERM,
    OP_ACCUM,
    OP_CLAMP,
    OP_PWM,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SRC_ERROR,
    SRC_DIFF,
    SRC_SUM,
    SRC_CONTROL
  } src_t;

  typedef enum logic [1:0] {
    GAIN_P,
    GAIN_D,
    GAIN_I,
    GAIN_SLOPE
  } gain_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t               op;
    src_t              src;
    gain_t             gain;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

endpackage

// ===== design/pprp_cfg_regs.sv =====
`timescale 1ns / 1ps
module pprp_cfg_regs import pprp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_step <= RST_TARGET_STEP;
      cfg.gain_p      <= RST_GAIN_P;
      cfg.gain_d      <= RST_GAIN_D;
      cfg.gain_i      <= RST_GAIN_I;
      cfg.pwm_floor   <= RST_PWM_FLOOR;
      cfg.pwm_ceiling <= RST_PWM_CEILING;
      cfg.pwm_slope   <= RST_PWM_SLOPE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_STEP: cfg.target_step <= cfg_data[23:0];
        REG_GAIN_P:      cfg.gain_p      <= cfg_data;
        REG_GAIN_D:      cfg.gain_d      <= cfg_data;
        REG_GAIN_I:      cfg.gain_i      <= cfg_data;
        REG_PWM_FLOOR:   cfg.pwm_floor   <= cfg_data[11:0];
        REG_PWM_CEILING: cfg.pwm_ceiling <= cfg_data[11:0];
        REG_PWM_SLOPE:   cfg.pwm_slope   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pprp_ucode_rom.sv =====
`timescale 1ns / 1ps
module pprp_ucode_rom import pprp_pkg::*; (
  input  logic [STEP_W-1:0] addr,
  output ctrl_word_t        word
);

  // Per tick: error update, then three gain terms (|x| lo/hi multiply,
  // saturate, accumulate), then |u| scaled onto the PWM range.
  always_comb begin
    word.op     = OP_IDLE;
    word.src    = SRC_ERROR;
    word.gain   = GAIN_P;
    word.cond   = COND_ALWAYS;
    word.target = addr + 1'b1;
    case (addr)
      5'd0: begin
        word.op   = OP_IDLE;
        word.cond = COND_IN_VALID;
      end
      5'd1:  word.op = OP_TARGET;
      5'd2:  word.op = OP_ERROR;
      5'd3:  word.op = OP_DIFF;
      5'd4: begin
        word.op  = OP_LOAD_MAG;
        word.src = SRC_ERROR;
      end
      5'd5: begin
        word.op   = OP_MUL_LO;
        word.gain = GAIN_P;
      end
      5'd6: begin
        word.op   = OP_MUL_HI;
        word.gain = GAIN_P;
      end
      5'd7:  word.op = OP_TERM;
      5'd8:  word.op = OP_ACCUM;
      5'd9: begin
        word.op  = OP_LOAD_MAG;
        word.src = SRC_DIFF;
      end
      5'd10: begin
        word.op   = OP_MUL_LO;
        word.gain = GAIN_D;
      end
      5'd11: begin
        word.op   = OP_MUL_HI;
        word.gain = GAIN_D;
      end
      5'd12: word.op = OP_TERM;
      5'd13: word.op = OP_ACCUM;
      5'd14: begin
        word.op  = OP_LOAD_MAG;
        word.src = SRC_SUM;
      end
      5'd15: begin
        word.op   = OP_MUL_LO;
        word.gain = GAIN_I;
      end
      5'd16: begin
        word.op   = OP_MUL_HI;
        word.gain = GAIN_I;
      end
      5'd17: word.op = OP_TERM;
      5'd18: word.op = OP_ACCUM;
      5'd19: begin
        word.op  = OP_LOAD_MAG;
        word.src = SRC_CONTROL;
      end
      5'd20: word.op = OP_CLAMP;
      5'd21: begin
        word.op   = OP_MUL_LO;
        word.gain = GAIN_SLOPE;
      end
      5'd22: begin
        word.op   = OP_MUL_HI;
        word.gain = GAIN_SLOPE;
      end
      5'd23: word.op = OP_TERM;
      5'd24: word.op = OP_PWM;
      5'd25: begin
        word.op     = OP_EMIT;
        word.cond   = COND_OUT_FREE;
        word.target = STEP_IDLE;
      end
      default: begin
        word.op     = OP_IDLE;
        word.target = STEP_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pprp_sequencer.sv =====
`timescale 1ns / 1ps
module pprp_sequencer import pprp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_word_t        word,
  input  status_t           status,
  output logic [STEP_W-1:0] step
);

  logic                advance;
  logic [STEP_W-1:0]   step_next;

  always_comb begin
    case (word.cond)
      COND_ALWAYS:   advance = 1'b1;
      COND_IN_VALID: advance = status.in_valid;
      COND_OUT_FREE: advance = status.out_free;
      default:       advance = 1'b1;
    endcase
    step_next = advance ? word.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== design/pprp_datapath.sv =====
`timescale 1ns / 1ps
module pprp_datapath import pprp_pkg::*; #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_word_t            word,
  input  cfg_t                  cfg,
  output status_t               status,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  localparam int ACC_BITS = (POSITION_BITS + FRACTION_BITS > 62) ? 62
                            : POSITION_BITS + FRACTION_BITS;
  localparam int SCALED_W = POS_W + FRACTION_BITS;
  localparam int ERR_W    = ((ACC_BITS > SCALED_W) ? ACC_BITS : SCALED_W) + 1;
  localparam int TW_W     = ACC_BITS + TW_OUT_W;
  localparam int PAD_W    = OUT_DATA_W - CMD_W - TW_OUT_W;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [POS_W-1:0]    position;
  logic [ACC_BITS-1:0]        target_accum;
  logic signed [ACC_BITS-1:0] last_error;
  logic signed [ACC_BITS-1:0] error_sum;
  logic signed [ACC_BITS-1:0] err;
  logic signed [ACC_BITS:0]   diff;
  logic [MAG_W-1:0]           mag;
  logic                       neg;
  logic [PROD_W-1:0]          prod;
  logic [PART_W-1:0]          part;
  logic [TERM_W-1:0]          term;
  logic signed [U_W-1:0]      u;
  logic                       clamped;
  logic [PWM_W-1:0]           pwm;

  logic signed [ACC_BITS-1:0] tgt_s;
  logic signed [ERR_W-1:0]    pos_scaled;
  logic signed [ERR_W-1:0]    err_wide;
  logic [ERR_W-ACC_BITS:0]    err_upper;
  logic signed [ACC_BITS-1:0] err_sat;
  logic signed [ACC_BITS:0]   sum_wide;
  logic signed [ACC_BITS-1:0] sum_sat;
  logic signed [PROD_W-1:0]   src_val;
  logic [PROD_W-1:0]          src_abs;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic [TERM_W-1:0]          term_sum;
  logic [TERM_W-1:0]          term_next;
  logic [U_W-1:0]             term_ext;
  logic [TERM_W-1:0]          scaled;
  logic                       scaled_over;
  logic [PWM_W:0]             pwm_sum;
  logic [CMD_W-1:0]           cmd;
  logic signed [TW_W-1:0]     tgt_ext;
  logic signed [TW_W-1:0]     tgt_shift;
  logic                       out_free;

  assign out_free        = !m_tvalid || m_tready;
  assign s_tready        = (word.op == OP_IDLE);
  assign status.in_valid = s_tvalid;
  assign status.out_free = out_free;

  // error = sat(target - position * 2^F)
  assign tgt_s      = signed'(target_accum);
  assign pos_scaled = ERR_W'(position) <<< FRACTION_BITS;
  assign err_wide   = ERR_W'(tgt_s) - pos_scaled;
  assign err_upper  = err_wide[ERR_W-1:ACC_BITS-1];
  always_comb begin
    if (&err_upper || ~|err_upper) begin
      err_sat = err_wide[ACC_BITS-1:0];
    end else begin
      err_sat = err_wide[ERR_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  assign sum_wide = (ACC_BITS+1)'(error_sum) + (ACC_BITS+1)'(err);
  always_comb begin
    if (sum_wide[ACC_BITS] == sum_wide[ACC_BITS-1]) begin
      sum_sat = sum_wide[ACC_BITS-1:0];
    end else begin
      sum_sat = sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
  end

  always_comb begin
    case (word.src)
      SRC_ERROR:   src_val = PROD_W'(err);
      SRC_DIFF:    src_val = PROD_W'(diff);
      SRC_SUM:     src_val = PROD_W'(error_sum);
      SRC_CONTROL: src_val = PROD_W'(u);
      default:     src_val = '0;
    endcase
    src_abs = src_val[PROD_W-1] ? PROD_W'(-src_val) : PROD_W'(src_val);
  end

  // shared 32x32 multiplier, magnitude in two halves
  assign mul_a = (word.op == OP_MUL_HI) ? 32'(mag[MAG_W-1:32]) : mag[31:0];
  always_comb begin
    case (word.gain)
      GAIN_P:     mul_b = cfg.gain_p;
      GAIN_D:     mul_b = cfg.gain_d;
      GAIN_I:     mul_b = cfg.gain_i;
      GAIN_SLOPE: mul_b = 32'(cfg.pwm_slope);
      default:    mul_b = '0;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // (hi << 16) + (lo >> 16), saturated at 2^60
  assign term_sum  = TERM_W'({prod[43:0], 16'd0}) + TERM_W'(part);
  assign term_next = (|prod[PROD_W-1:44] || term_sum > TERM_LIMIT) ? TERM_LIMIT : term_sum;
  assign term_ext  = U_W'(term);

  assign scaled      = term >> FRACTION_BITS;
  assign scaled_over = |scaled[TERM_W-1:PWM_W];
  assign pwm_sum     = {1'b0, cfg.pwm_floor} + {1'b0, scaled[PWM_W-1:0]};

  assign cmd       = neg ? CMD_W'(-{1'b0, pwm}) : {1'b0, pwm};
  assign tgt_ext   = TW_W'(tgt_s);
  assign tgt_shift = tgt_ext >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_accum <= '0;
      last_error   <= '0;
      error_sum    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (word.op == OP_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (word.op)
        OP_IDLE: begin
          if (s_tvalid) begin
            position <= signed'(s_tdata);
          end
        end
        OP_TARGET: begin
          target_accum <= target_accum + ACC_BITS'(cfg.target_step);
          u            <= '0;
        end
        OP_ERROR: err <= err_sat;
        OP_DIFF: begin
          diff       <= (ACC_BITS+1)'(err) - (ACC_BITS+1)'(last_error);
          error_sum  <= sum_sat;
          last_error <= err;
        end
        OP_LOAD_MAG: begin
          mag <= src_abs[MAG_W-1:0];
          if (word.src == SRC_CONTROL) begin
            neg <= u[U_W-1] || (u == '0);
          end else begin
            neg <= src_val[PROD_W-1];
          end
        end
        OP_MUL_LO: prod <= mul_p;
        OP_MUL_HI: begin
          part <= prod[PROD_W-1:16];
          prod <= mul_p;
        end
        OP_TERM: term <= term_next;
        OP_ACCUM: begin
          if (neg) begin
            u <= u - signed'(term_ext);
          end else begin
            u <= u + signed'(term_ext);
          end
        end
        OP_CLAMP: clamped <= mag > MAG_W'({cfg.pwm_ceiling, {FRACTION_BITS{1'b0}}});
        OP_PWM: begin
          if (clamped) begin
            pwm <= cfg.pwm_ceiling;
          end else if (scaled_over || pwm_sum[PWM_W]) begin
            pwm <= PWM_MAX;
          end else begin
            pwm <= pwm_sum[PWM_W-1:0];
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            m_tdata  <= {{PAD_W{1'b0}}, tgt_shift[TW_OUT_W-1:0], cmd};
            m_tuser  <= clamped;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pid_position_ramp_pwm_core.sv =====
`timescale 1ns / 1ps
// The result beat is registered in the emit step, which waits for a free output register.
// One item is in flight at a time: a new input beat is taken only in the idle step of the
// 26-step microprogram that runs all eight products through one shared 32x32 multiplier.
// Reset (rst, synchronous): target, last error and error sum go to zero,
// registers to their defaults, the output register empties.
`include "assert_macros.svh"
module pid_position_ramp_pwm_core import pprp_pkg::*; #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] measured_position
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [12:0] pwm_command, [44:13] target_whole
  output logic                   m_tuser,   // [0] output_clamped
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t              cfg;
  ctrl_word_t        word;
  status_t           status;
  logic [STEP_W-1:0] step;

  pprp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pprp_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .word   (word),
    .status (status),
    .step   (step)
  );

  pprp_ucode_rom u_ucode_rom (
    .addr (step),
    .word (word)
  );

  pprp_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .word     (word),
    .cfg      (cfg),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `ASSERT_NEXT(a_one_item_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `ASSERT_IMPLIES(a_load_on_emit, clk, rst, $rose(m_tvalid), $past(word.op == OP_EMIT), "result without emit step")
  `ASSERT_IMPLIES(a_step_range, clk, rst, 1'b1, step <= STEP_LAST, "step counter out of program")

endmodule

// ===== test/pid_position_ramp_pwm_checker.sv =====
`timescale 1ns / 1ps
module pid_position_ramp_pwm_checker import pprp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] measured_position
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_DATA_W-1:0]  m_tdata,   // [12:0] pwm_command, [44:13] target_whole
  input  logic                   m_tuser,   // [0] output_clamped
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  localparam longint ERR_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint ERR_MIN = -(64'sd1 <<< 47);

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TW_OUT_W-1:0] target_whole;
    logic                clamped;
  } drive_t;

  cfg_t        regs;
  logic [47:0] ramp_acc;
  longint      prev_err;
  longint      err_total;
  drive_t      pending_drive[$];
  int          fail_count = 0;

  function automatic longint clip_err(input longint v);
    if (v > ERR_MAX) return ERR_MAX;
    if (v < ERR_MIN) return ERR_MIN;
    return v;
  endfunction

  // |x| * gain in Q16.16, truncated, capped at 2^60, sign put back
  function automatic longint scaled_term(input longint x, input logic [31:0] gain);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] t;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    prod = (96'(mag) * 96'(gain)) >> 16;
    t = (prod > 96'(TERM_LIMIT)) ? 64'(TERM_LIMIT) : prod[63:0];
    return (x < 0) ? -$signed(t) : $signed(t);
  endfunction

  function automatic drive_t drive_for_position(input logic [31:0] pos_bits);
    longint      target;
    longint      pos;
    longint      err;
    longint      delta;
    longint      u;
    logic [63:0] mag;
    logic [63:0] level;
    logic [63:0] cmd;
    drive_t      d;
    ramp_acc = ramp_acc + 48'(regs.target_step);
    target = $signed({{16{ramp_acc[47]}}, ramp_acc});
    pos = $signed({{32{pos_bits[31]}}, pos_bits});
    err = clip_err(target - (pos <<< 16));
    delta = err - prev_err;
    err_total = clip_err(err_total + err);
    u = scaled_term(err, regs.gain_p) + scaled_term(delta, regs.gain_d)
      + scaled_term(err_total, regs.gain_i);
    prev_err = err;
    mag = (u < 0) ? 64'(-u) : 64'(u);
    d.clamped = mag > (64'(regs.pwm_ceiling) << 16);
    if (d.clamped) begin
      level = 64'(regs.pwm_ceiling);
    end else begin
      level = 64'(regs.pwm_floor) + ((mag * 64'(regs.pwm_slope)) >> 32);
      if (level > 64'(PWM_MAX)) level = 64'(PWM_MAX);
    end
    // zero control drives the negative direction
    cmd = (u > 0) ? level : (64'd0 - level);
    d.command = cmd[CMD_W-1:0];
    d.target_whole = ramp_acc[47:16];
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 100)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      regs = '{target_step: RST_TARGET_STEP, gain_p: RST_GAIN_P, gain_d: RST_GAIN_D,
               gain_i: RST_GAIN_I, pwm_floor: RST_PWM_FLOOR,
               pwm_ceiling: RST_PWM_CEILING, pwm_slope: RST_PWM_SLOPE};
      ramp_acc = '0;
      prev_err = 0;
      err_total = 0;
      pending_drive.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_STEP: regs.target_step = cfg_data[23:0];
          REG_GAIN_P:      regs.gain_p = cfg_data;
          REG_GAIN_D:      regs.gain_d = cfg_data;
          REG_GAIN_I:      regs.gain_i = cfg_data;
          REG_PWM_FLOOR:   regs.pwm_floor = cfg_data[11:0];
          REG_PWM_CEILING: regs.pwm_ceiling = cfg_data[11:0];
          REG_PWM_SLOPE:   regs.pwm_slope = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (pending_drive.size() == 0) begin
          report_mismatch("beat with nothing expected", 32'(m_tdata[12:0]), '0);
        end else begin
          want = pending_drive.pop_front();
          if (m_tdata[12:0] !== want.command)
            report_mismatch("pwm_command", 32'(m_tdata[12:0]), 32'(want.command));
          if (m_tdata[44:13] !== want.target_whole)
            report_mismatch("target_whole", m_tdata[44:13], want.target_whole);
          if (m_tuser !== want.clamped)
            report_mismatch("output_clamped", 32'(m_tuser), 32'(want.clamped));
        end
      end
      if (s_tvalid && s_tready)
        pending_drive.push_back(drive_for_position(s_tdata));
    end
    mismatches <= fail_count;
    outstanding <= pending_drive.size();
  end

endmodule

// ===== test/pid_position_ramp_pwm_core_test.sv =====
`timescale 1ns / 1ps
module pid_position_ramp_pwm_core_test;
  import pprp_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 16;
  localparam int PHASE_BEATS  = 80;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     outstanding;

  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  logic [47:0] ramp = '0;
  logic [23:0] ramp_step = RST_TARGET_STEP;
  logic [31:0] last_pos = '0;

  pid_position_ramp_pwm_core u_top (.*);
  pid_position_ramp_pwm_checker u_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sink side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_tready <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic [31:0] ramp_ahead();
    logic [47:0] ahead;
    ahead = ramp + 48'(ramp_step);
    return ahead[47:16];
  endfunction

  function automatic logic [31:0] random_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return ramp_ahead() + 32'($urandom_range(0, 8)) - 32'd4;
    if (r < 70) return ramp_ahead() + 32'($urandom_range(0, 4000)) - 32'd2000;
    if (r < 75) return last_pos;
    if (r < 93) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      3:       return $urandom_range(0, 1 << 17);
      default: return $urandom_range(0, 1 << 14);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    int   ceil_v;
    int   floor_v;
    case ($urandom_range(0, 3))
      0:       c.target_step = '0;
      1:       c.target_step = '1;
      2:       c.target_step = 24'($urandom());
      default: c.target_step = 24'($urandom_range(0, 1 << 18));
    endcase
    c.gain_p = pick_gain();
    c.gain_d = pick_gain();
    // large integral gains lock the output into clamp, so keep them rare
    c.gain_i = ($urandom_range(0, 3) == 0) ? pick_gain() : 32'($urandom_range(0, 16));
    case ($urandom_range(0, 4))
      0:       ceil_v = 0;
      1:       ceil_v = 4095;
      2:       ceil_v = 1;
      default: ceil_v = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(0, 4))
      0:       floor_v = 0;
      1:       floor_v = 4095;
      2:       floor_v = $urandom_range(0, 4095);
      default: floor_v = $urandom_range(0, ceil_v);
    endcase
    c.pwm_ceiling = 12'(ceil_v);
    c.pwm_floor = 12'(floor_v);
    case ($urandom_range(0, 3))
      0:       c.pwm_slope = '0;
      1:       c.pwm_slope = '1;
      2:       c.pwm_slope = 16'($urandom());
      default: c.pwm_slope = (ceil_v == 0 || floor_v > ceil_v) ? 16'd0 :
                             16'(((ceil_v - floor_v) * 65536) / ceil_v);
    endcase
    return c;
  endfunction

  task automatic push_position(input logic [31:0] pos);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pos;
    do @(posedge clk); while (!s_tready);
    ramp = ramp + 48'(ramp_step);
    last_pos = pos;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused upper data bits carry junk
  task automatic program_regs(input cfg_t c);
    write_reg(REG_TARGET_STEP, {8'($urandom()), c.target_step});
    write_reg(REG_GAIN_P, c.gain_p);
    write_reg(REG_GAIN_D, c.gain_d);
    write_reg(REG_GAIN_I, c.gain_i);
    write_reg(REG_PWM_FLOOR, {20'($urandom()), c.pwm_floor});
    write_reg(REG_PWM_CEILING, {20'($urandom()), c.pwm_ceiling});
    write_reg(REG_PWM_SLOPE, {16'($urandom()), c.pwm_slope});
    cfg_valid <= 1'b0;
    ramp_step = c.target_step;
  endtask

  initial begin
    cfg_t plan;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults: tracking, position extremes, error and sum saturation
    push_position('0);
    push_position('0);
    push_position(ramp_ahead());
    push_position(ramp_ahead() + 32'd1);
    push_position('1);
    push_position(32'h7FFF_FFFF);
    push_position(32'h8000_0000);
    push_position(32'h8000_0000);
    push_position(32'h5555_5555);
    push_position(32'hAAAA_AAAA);

    // all gains zero: zero control
    wait_idle();
    plan = '{target_step: RST_TARGET_STEP, gain_p: '0, gain_d: '0, gain_i: '0,
             pwm_floor: RST_PWM_FLOOR, pwm_ceiling: RST_PWM_CEILING,
             pwm_slope: RST_PWM_SLOPE};
    write_reg(REG_UNMAPPED, $urandom());
    program_regs(plan);
    push_position($urandom());
    push_position('0);

    // zero ceiling
    wait_idle();
    plan = '{target_step: RST_TARGET_STEP, gain_p: RST_GAIN_P, gain_d: RST_GAIN_D,
             gain_i: '0, pwm_floor: RST_PWM_FLOOR, pwm_ceiling: '0,
             pwm_slope: RST_PWM_SLOPE};
    program_regs(plan);
    push_position(32'h7FFF_FFFF);
    push_position(ramp_ahead() - 32'd5);

    // floor plus slope overruns the command range
    wait_idle();
    plan = '{target_step: RST_TARGET_STEP, gain_p: 32'h0001_0000, gain_d: '0,
             gain_i: '0, pwm_floor: '1, pwm_ceiling: '1, pwm_slope: '1};
    program_regs(plan);
    push_position(ramp_ahead() - 32'd3);
    push_position(ramp_ahead() + 32'd3);

    // maximum gains and step: every term hits its cap
    wait_idle();
    plan = '{target_step: '1, gain_p: '1, gain_d: '1, gain_i: '1,
             pwm_floor: '0, pwm_ceiling: '1, pwm_slope: '1};
    program_regs(plan);
    push_position(32'h8000_0000);
    push_position(32'h8000_0000);
    push_position(32'h7FFF_FFFF);
    push_position(32'h7FFF_FFFF);

    for (int k = 0; k < PHASES; k++) begin
      wait_idle();
      program_regs(random_settings());
      case (k % 4)
        0: begin
          tx_gap_pct <= 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_gap_pct <= 45;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_gap_pct <= 0;
          rx_stall_pct <= 45;
        end
        default: begin
          tx_gap_pct <= 37;
          rx_stall_pct <= 37;
        end
      endcase
      if (k == 4) hold_req <= ~hold_req;
      for (int n = 0; n < PHASE_BEATS; n++)
        push_position(random_position());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== pid_position_ramp_pwm_core.f =====
+incdir+design
design/pprp_pkg.sv
design/pprp_cfg_regs.sv
design/pprp_ucode_rom.sv
design/pprp_sequencer.sv
design/pprp_datapath.sv
design/pid_position_ramp_pwm_core.sv
test/pid_position_ramp_pwm_checker.sv
test/pid_position_ramp_pwm_core_test.sv
